// ----- rtl/core/cmdkw_pkg.sv -----
package cmdkw_pkg;

    localparam int LINE_BYTES  = 256;
    localparam int KEY_ENTRIES = 7;
    localparam int KEY_CHARS   = 8;
    localparam int CNT_W       = $clog2(LINE_BYTES) + 1;

    localparam int KEY_W   = 64;
    localparam int HP_W    = 3 * KEY_ENTRIES;
    localparam int ENTRY_W = 3;
    localparam int LEN_W   = 4;

    // register map: keywords at 0..KEY_ENTRIES-1, handler mask after them
    localparam int ADDR_W = 6;
    localparam logic [2:0] REG_HANDLER = 3'(KEY_ENTRIES);

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_QUERY = 8'h3F;
    localparam logic [7:0] CH_COLON = 8'h3A;

    typedef enum logic [2:0] {
        ST_SET      = 3'd0,
        ST_GET      = 3'd1,
        ST_PREFIX   = 3'd2,
        ST_SYNTAX   = 3'd3,
        ST_OVERFLOW = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        OC_PENDING = 2'd0,
        OC_SET     = 2'd1,
        OC_GET     = 2'd2,
        OC_PREFIX  = 2'd3
    } outcome_t;

    typedef struct packed {
        logic             adv;
        logic             start;
        logic             step;
        logic [7:0]       rx;
        logic [CNT_W-1:0] pos;
    } lane_ctl_t;

    typedef struct packed {
        logic             hit;
        outcome_t         oc;
        logic [LEN_W-1:0] len;
    } lane_stat_t;

    function automatic logic is_blank(input logic [7:0] c);
        return c inside {CH_SPACE, CH_TAB, CH_VT};
    endfunction

    function automatic logic is_term(input logic [7:0] c);
        return c inside {CH_CR, CH_LF, CH_NUL};
    endfunction

    function automatic logic [LEN_W-1:0] key_len(input logic [KEY_W-1:0] kw);
        logic [LEN_W-1:0] len;
        logic             done;
        len  = LEN_W'(KEY_CHARS);
        done = 1'b0;
        for (int p = 0; p < KEY_CHARS; p++)
        begin
            if (!done && kw[8*p +: 8] == CH_NUL)
            begin
                len  = LEN_W'(p);
                done = 1'b1;
            end
        end
        return len;
    endfunction

endpackage

// ----- rtl/core/cmdkw_lane.sv -----
module cmdkw_lane (
    input  logic                         clk,
    input  logic                         rst_n,
    input  cmdkw_pkg::lane_ctl_t         ctl,
    input  logic                         table_ok,
    input  logic [cmdkw_pkg::KEY_W-1:0]  keyword,
    output cmdkw_pkg::lane_stat_t        stat
);

    logic                          alive_reg;
    logic                          alive_next;
    cmdkw_pkg::outcome_t           outcome_reg;
    cmdkw_pkg::outcome_t           outcome_next;
    logic                          alive_eff;
    cmdkw_pkg::outcome_t           outcome_eff;
    cmdkw_pkg::outcome_t           outcome_fin;
    logic [cmdkw_pkg::LEN_W-1:0]   len;
    logic [cmdkw_pkg::CNT_W-1:0]   len_ext;
    logic [7:0]                    key_b;

    assign len     = cmdkw_pkg::key_len(keyword);
    assign len_ext = cmdkw_pkg::CNT_W'(len);
    assign key_b   = keyword[{ctl.pos[2:0], 3'b000} +: 8];

    // a new command reloads the lane from the table
    assign alive_eff   = ctl.start ? table_ok : alive_reg;
    assign outcome_eff = ctl.start ? cmdkw_pkg::OC_PENDING : outcome_reg;

    always_comb
    begin
        alive_next   = alive_eff;
        outcome_next = outcome_eff;
        if (ctl.step && alive_eff && outcome_eff == cmdkw_pkg::OC_PENDING)
        begin
            if (ctl.pos < len_ext)
            begin
                if (cmdkw_pkg::is_blank(ctl.rx) || ctl.rx != key_b)
                    alive_next = 1'b0;
            end
            else if (ctl.pos == len_ext)
            begin
                if (cmdkw_pkg::is_blank(ctl.rx))
                    outcome_next = cmdkw_pkg::OC_SET;
                else if (ctl.rx == cmdkw_pkg::CH_QUERY)
                    outcome_next = cmdkw_pkg::OC_GET;
                else if (ctl.rx == cmdkw_pkg::CH_COLON)
                    outcome_next = cmdkw_pkg::OC_PREFIX;
                else
                    alive_next = 1'b0;
            end
        end
    end

    // keyword ending exactly at the terminator counts as set
    always_comb
    begin
        outcome_fin = outcome_eff;
        if (outcome_eff == cmdkw_pkg::OC_PENDING && ctl.pos == len_ext)
            outcome_fin = cmdkw_pkg::OC_SET;
    end

    assign stat.hit = alive_eff && outcome_fin != cmdkw_pkg::OC_PENDING;
    assign stat.oc  = outcome_fin;
    assign stat.len = len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alive_reg   <= 1'b0;
            outcome_reg <= cmdkw_pkg::OC_PENDING;
        end
        else if (ctl.adv)
        begin
            alive_reg   <= alive_next;
            outcome_reg <= outcome_next;
        end
    end

endmodule

// ----- rtl/core/command_line_keyword_dispatch.sv -----
// Command line keyword dispatcher. One received byte is taken per beat on the rx
// channel and a new beat can be taken every cycle while the result register is
// not held by res_stall; each byte passes an input register, the matching logic
// and the result register. Leading space, tab and vertical tab are skipped, a
// command ends at CR, LF or NUL, and the terminator produces one result beat. A
// command reaching LINE_BYTES bytes produces one overflow beat and is dropped up
// to its terminator. The seven keyword registers and the handler mask sit on a
// 64-bit APB port at byte address 8*i and may only be changed while no byte is
// in flight.
module command_line_keyword_dispatch (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cmdkw_pkg::ADDR_W-1:0]       paddr,
    input  logic [63:0]                        pwdata,
    output logic [63:0]                        prdata,
    output logic                               pready,
    input  logic                               rx_valid,
    output logic                               rx_stall,
    input  logic [7:0]                         rx_byte,
    output logic                               res_valid,
    input  logic                               res_stall,
    output logic [2:0]                         status,
    output logic [cmdkw_pkg::ENTRY_W-1:0]      entry,
    output logic [3:0]                         arg_offset,
    output logic [7:0]                         line_length
);

    localparam int NE = cmdkw_pkg::KEY_ENTRIES;
    localparam int CW = cmdkw_pkg::CNT_W;

    logic [cmdkw_pkg::KEY_W-1:0] keyword_reg [NE];
    logic [cmdkw_pkg::HP_W-1:0]  handler_reg;
    logic [2:0]                  reg_idx;

    logic                        in_valid_reg;
    logic [7:0]                  in_byte_reg;
    logic                        in_cmd_reg;
    logic                        in_cmd_next;
    logic                        ovf_reg;
    logic                        ovf_next;
    logic [CW-1:0]               cnt_reg;
    logic [CW-1:0]               cnt_next;
    logic                        res_valid_reg;
    cmdkw_pkg::status_t          status_reg;
    cmdkw_pkg::status_t          status_next;
    logic [cmdkw_pkg::ENTRY_W-1:0] entry_reg;
    logic [cmdkw_pkg::ENTRY_W-1:0] entry_next;
    logic [3:0]                  arg_reg;
    logic [3:0]                  arg_next;
    logic [7:0]                  len_reg;
    logic [7:0]                  len_next;
    logic                        emit;

    logic                        advance;
    logic                        fire;
    logic                        blank;
    logic                        term;
    logic                        start;
    logic                        ovf_eff;
    logic [CW-1:0]               cnt_eff;
    logic [CW-1:0]               cnt_inc;
    logic [NE-1:0]               table_ok;
    cmdkw_pkg::lane_ctl_t        lane_ctl;
    cmdkw_pkg::lane_stat_t       lane_stat [NE];

    // configuration port
    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];

    always_comb
    begin
        prdata = '0;
        if (reg_idx == cmdkw_pkg::REG_HANDLER)
            prdata = 64'(handler_reg);
        else if (reg_idx < cmdkw_pkg::REG_HANDLER)
            prdata = keyword_reg[reg_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int e = 0; e < NE; e++)
                keyword_reg[e] <= '0;
            handler_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            if (reg_idx == cmdkw_pkg::REG_HANDLER)
                handler_reg <= pwdata[cmdkw_pkg::HP_W-1:0];
            else if (reg_idx < cmdkw_pkg::REG_HANDLER)
                keyword_reg[reg_idx] <= pwdata;
        end
    end

    // table ends at the first zero keyword
    always_comb
    begin
        for (int e = 0; e < NE; e++)
        begin
            if (e == 0)
                table_ok[e] = keyword_reg[e] != '0;
            else
                table_ok[e] = table_ok[e-1] && keyword_reg[e] != '0;
        end
    end

    // input register and result register
    assign advance  = !res_valid_reg || !res_stall;
    assign rx_stall = in_valid_reg && !advance;
    assign fire     = in_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (rx_valid && !rx_stall)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (rx_valid && !rx_stall)
            in_byte_reg <= rx_byte;
    end

    // command framing
    assign blank   = cmdkw_pkg::is_blank(in_byte_reg);
    assign term    = cmdkw_pkg::is_term(in_byte_reg);
    assign start   = !in_cmd_reg && !blank;
    assign ovf_eff = start ? 1'b0 : ovf_reg;
    assign cnt_eff = start ? '0 : cnt_reg;
    assign cnt_inc = cnt_eff + CW'(1);

    assign lane_ctl.adv   = fire && (in_cmd_reg || !blank);
    assign lane_ctl.start = start;
    assign lane_ctl.step  = !ovf_eff && !term;
    assign lane_ctl.rx    = in_byte_reg;
    assign lane_ctl.pos   = cnt_eff;

    for (genvar g = 0; g < NE; g++)
    begin : g_lane
        cmdkw_lane u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (lane_ctl),
            .table_ok (table_ok[g]),
            .keyword  (keyword_reg[g]),
            .stat     (lane_stat[g])
        );
    end

    always_comb
    begin
        in_cmd_next = in_cmd_reg;
        ovf_next    = ovf_reg;
        cnt_next    = cnt_reg;
        emit        = 1'b0;
        status_next = cmdkw_pkg::ST_SYNTAX;
        entry_next  = '0;
        arg_next    = '0;
        len_next    = cnt_eff[7:0];
        if (!in_cmd_reg && blank)
        begin
            // leading whitespace dropped
        end
        else if (ovf_eff)
        begin
            if (term)
            begin
                in_cmd_next = 1'b0;
                ovf_next    = 1'b0;
                cnt_next    = '0;
            end
        end
        else if (term)
        begin
            emit        = 1'b1;
            in_cmd_next = 1'b0;
            ovf_next    = 1'b0;
            cnt_next    = cnt_eff;
            // first hit in table order wins
            for (int e = NE - 1; e >= 0; e--)
            begin
                if (lane_stat[e].hit)
                begin
                    entry_next = cmdkw_pkg::ENTRY_W'(e);
                    arg_next   = lane_stat[e].len
                                 + ((lane_stat[e].oc == cmdkw_pkg::OC_SET) ? 4'd0 : 4'd1);
                    case (lane_stat[e].oc)
                        cmdkw_pkg::OC_SET:
                            status_next = handler_reg[3*e]     ? cmdkw_pkg::ST_SET
                                                               : cmdkw_pkg::ST_SYNTAX;
                        cmdkw_pkg::OC_GET:
                            status_next = handler_reg[3*e + 1] ? cmdkw_pkg::ST_GET
                                                               : cmdkw_pkg::ST_SYNTAX;
                        cmdkw_pkg::OC_PREFIX:
                            status_next = handler_reg[3*e + 2] ? cmdkw_pkg::ST_PREFIX
                                                               : cmdkw_pkg::ST_SYNTAX;
                        default:
                            status_next = cmdkw_pkg::ST_SYNTAX;
                    endcase
                end
            end
        end
        else
        begin
            in_cmd_next = 1'b1;
            ovf_next    = 1'b0;
            cnt_next    = cnt_inc;
            if (cnt_inc >= CW'(cmdkw_pkg::LINE_BYTES))
            begin
                emit        = 1'b1;
                ovf_next    = 1'b1;
                status_next = cmdkw_pkg::ST_OVERFLOW;
                len_next    = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_cmd_reg    <= 1'b0;
            ovf_reg       <= 1'b0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= fire && emit;
            if (fire)
            begin
                in_cmd_reg <= in_cmd_next;
                ovf_reg    <= ovf_next;
                cnt_reg    <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && fire && emit)
        begin
            status_reg <= status_next;
            entry_reg  <= entry_next;
            arg_reg    <= arg_next;
            len_reg    <= len_next;
        end
    end

    assign res_valid   = res_valid_reg;
    assign status      = status_reg;
    assign entry       = entry_reg;
    assign arg_offset  = arg_reg;
    assign line_length = len_reg;

    a_ovf_in_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> in_cmd_reg)
        else $error("overflow flag set outside a command");

    a_ovf_beat: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && status_reg == cmdkw_pkg::ST_OVERFLOW
        |-> entry_reg == '0 && arg_reg == '0 && len_reg == '0)
        else $error("overflow beat carries match fields");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        rx_stall |-> in_valid_reg && res_valid_reg)
        else $error("rx stalled with room to advance");

    a_no_beat_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_stall |=> res_valid_reg)
        else $error("result beat lost while stalled");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !ovf_reg |-> cnt_reg < CW'(cmdkw_pkg::LINE_BYTES))
        else $error("byte count past line capacity without overflow");

endmodule
